>>> hw/rtl/cfr_pkg.sv
// Shared types and constants for the circle fill rasterizer.
// Used by cfr_sweep and circle_fill_rasterizer_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  // Default sizing handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 8;

  // Fixed field widths.
  localparam int COORD_W     = 19;
  localparam int CHAR_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int PIX_W       = 9;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 16;

  // Command codes carried on the slave tuser.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0]  RST_CANVAS_WIDTH  = 10'd512;
  localparam logic [CFG_W-1:0]  RST_CANVAS_HEIGHT = 10'd512;
  localparam logic [CHAR_W-1:0] RST_BACKGROUND    = 8'd32;

  // The two accepted shape bytes, lower and upper case c.
  localparam logic [CHAR_W-1:0] SHAPE_LOWER = 8'd99;
  localparam logic [CHAR_W-1:0] SHAPE_UPPER = 8'd67;

  // One sweep request from the command controller to the raster engine.
  typedef struct packed {
    logic                      is_clear;
    logic [CHAR_W-1:0]         fill_char;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] radius;
  } sweep_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/cfr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined after reset.
`timescale 1ns / 1ps
`default_nettype none

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cfr_sweep.sv
// Raster engine: walks the in-use canvas one pixel a cycle and drives the RAM write port.
// Distances are kept by incremental update, so only the start needs multiplications.
// Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_sweep #(
  parameter int MAX_WIDTH  = cfr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfr_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = cfr_pkg::DEF_FRAC_BITS,
  localparam int COL_CNT_W = $clog2(MAX_WIDTH + 1),
  localparam int ROW_CNT_W = $clog2(MAX_HEIGHT + 1),
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire cfr_pkg::sweep_req_t           req_i,
  input  wire logic [COL_CNT_W-1:0]          used_w_i,
  input  wire logic [ROW_CNT_W-1:0]          used_h_i,
  output      logic                          done_o,
  output      logic                          we_o,
  output      logic [ADDR_W-1:0]             waddr_o,
  output      logic [cfr_pkg::CHAR_W-1:0]    wdata_o
);

  import cfr_pkg::*;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // Position in fixed point, with headroom for one step past the last pixel.
  localparam int POS_W   = $clog2(MAX_DIM + 1) + FRAC_BITS + 1;
  localparam int DX_W    = ((POS_W + 1 > COORD_W) ? POS_W + 1 : COORD_W) + 1;
  localparam int ACC_W   = 2 * DX_W + 2;
  localparam int PROD_W  = 2 * COORD_W;

  typedef enum logic [2:0] {
    SW_IDLE,
    SW_MUL_X,
    SW_MUL_Y,
    SW_MUL_R,
    SW_INIT,
    SW_SCAN,
    SW_FLUSH
  } sw_state_e;

  // Step constants: S squared and twice S squared, S being one pixel in fixed point.
  localparam logic signed [ACC_W-1:0] STEP_SQ  = ACC_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] STEP_SQ2 = ACC_W'(1) << (2 * FRAC_BITS + 1);

  sw_state_e                 state_q;
  sweep_req_t                req_q;
  logic [COL_W-1:0]          col_q;
  logic [ROW_W-1:0]          row_q;
  logic                      p_valid_q;

  logic signed [PROD_W-1:0]  prod_q;
  logic signed [COORD_W-1:0] mul_a;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]   cx2_q;
  logic signed [ACC_W-1:0]   dx2_q;
  logic signed [ACC_W-1:0]   dy2_q;
  logic signed [ACC_W-1:0]   tx_q;
  logic signed [ACC_W-1:0]   tx0_q;
  logic signed [ACC_W-1:0]   ty_q;
  logic signed [ACC_W-1:0]   r2_q;
  logic signed [ACC_W-1:0]   p_sum_q;
  logic [ADDR_W-1:0]         p_addr_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [ADDR_W-1:0]         row_base_q;

  logic signed [ACC_W-1:0]   cx_ext;
  logic signed [ACC_W-1:0]   cy_ext;
  logic                      last_col;
  logic                      last_row;
  logic                      empty_area;

  // Shared squarer: centre x, centre y, then radius.
  always_comb begin
    unique case (state_q)
      SW_MUL_X: mul_a = req_q.cx;
      SW_MUL_Y: mul_a = req_q.cy;
      default:  mul_a = req_q.radius;
    endcase
    prod_d = mul_a * mul_a;
  end

  assign cx_ext     = ACC_W'($signed(req_q.cx));
  assign cy_ext     = ACC_W'($signed(req_q.cy));
  assign last_col   = (COL_CNT_W'(col_q) == used_w_i - COL_CNT_W'(1));
  assign last_row   = (ROW_CNT_W'(row_q) == used_h_i - ROW_CNT_W'(1));
  assign empty_area = (used_w_i == '0) || (used_h_i == '0);

  // Sequencer and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SW_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= (state_q == SW_SCAN);
      unique case (state_q)
        SW_IDLE: begin
          if (start_i) begin
            state_q <= SW_MUL_X;
          end
        end
        SW_MUL_X: state_q <= SW_MUL_Y;
        SW_MUL_Y: state_q <= SW_MUL_R;
        SW_MUL_R: state_q <= SW_INIT;
        SW_INIT: begin
          col_q   <= '0;
          row_q   <= '0;
          state_q <= empty_area ? SW_FLUSH : SW_SCAN;
        end
        SW_SCAN: begin
          if (last_col) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
            if (last_row) begin
              state_q <= SW_FLUSH;
            end
          end else begin
            col_q <= col_q + COL_W'(1);
          end
        end
        SW_FLUSH: state_q <= SW_IDLE;
        default:  state_q <= SW_IDLE;
      endcase
    end
  end

  // Distance accumulators and the one-stage pixel pipeline.
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    p_sum_q  <= dx2_q + dy2_q;
    p_addr_q <= addr_q;
    if (state_q == SW_IDLE && start_i) begin
      req_q <= req_i;
    end
    unique case (state_q)
      SW_MUL_Y: cx2_q <= ACC_W'(prod_q);
      SW_MUL_R: dy2_q <= ACC_W'(prod_q);
      SW_INIT: begin
        r2_q       <= ACC_W'(prod_q);
        dx2_q      <= cx2_q;
        tx_q       <= STEP_SQ - (cx_ext <<< (FRAC_BITS + 1));
        tx0_q      <= STEP_SQ - (cx_ext <<< (FRAC_BITS + 1));
        ty_q       <= STEP_SQ - (cy_ext <<< (FRAC_BITS + 1));
        addr_q     <= '0;
        row_base_q <= '0;
      end
      SW_SCAN: begin
        if (last_col) begin
          dx2_q      <= cx2_q;
          tx_q       <= tx0_q;
          dy2_q      <= dy2_q + ty_q;
          ty_q       <= ty_q + STEP_SQ2;
          row_base_q <= row_base_q + ADDR_W'(MAX_WIDTH);
          addr_q     <= row_base_q + ADDR_W'(MAX_WIDTH);
        end else begin
          dx2_q  <= dx2_q + tx_q;
          tx_q   <= tx_q + STEP_SQ2;
          addr_q <= addr_q + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // A clear writes every in-use pixel; a draw only those inside the circle.
  assign we_o    = p_valid_q && (req_q.is_clear || (p_sum_q <= r2_q));
  assign waddr_o = p_addr_q;
  assign wdata_o = req_q.fill_char;
  assign done_o  = (state_q == SW_FLUSH);

endmodule

`default_nettype wire

>>> hw/rtl/circle_fill_rasterizer_top.sv
// Filled-circle rasterizer on a character canvas held in one synchronous RAM.
// A clear or a draw walks the in-use area row by row, one pixel per cycle through the
// single RAM write port, the sizes being saturated to MAX_WIDTH and MAX_HEIGHT. A draw
// that is rejected or ignored, a read outside the in-use area and an unused code go
// straight to the result, and a read inside the area first reads the RAM. A result
// waits while the one before it is held and m_axis_tready_i is low. The canvas is not
// cleared by reset: issue a clear before the first read.
// Depends on cfr_pkg, cfr_ram and cfr_sweep.
`timescale 1ns / 1ps
`default_nettype none

module circle_fill_rasterizer_top #(
  parameter int MAX_WIDTH  = cfr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfr_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = cfr_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Slave side. tdata, from bit 0: shape_code[7:0], center_x[26:8], center_y[45:27],
  // radius[64:46], paint_char[72:65], pixel_row[81:73], pixel_col[90:82], zeros.
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  input  wire logic [cfr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // tuser, from bit 0: func[1:0].
  input  wire logic [cfr_pkg::FUNC_W-1:0]        s_axis_tuser_i,
  // Master side. tdata, from bit 0: pixel_value[7:0], corrupted[8], zeros.
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output      logic [cfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [cfr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cfr_pkg::CFG_W-1:0]         cfg_data_i
);

  import cfr_pkg::*;

  localparam int COL_CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_CNT_W = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCMP_W    = (COL_CNT_W > CFG_W) ? COL_CNT_W : CFG_W;
  localparam int HCMP_W    = (ROW_CNT_W > CFG_W) ? ROW_CNT_W : CFG_W;
  localparam int PCMP_W    = (WCMP_W > HCMP_W) ? WCMP_W : HCMP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_RESULT
  } state_e;

  // Input item fields.
  logic [CHAR_W-1:0]         in_shape;
  logic signed [COORD_W-1:0] in_cx;
  logic signed [COORD_W-1:0] in_cy;
  logic signed [COORD_W-1:0] in_radius;
  logic [CHAR_W-1:0]         in_paint;
  logic [PIX_W-1:0]          in_row;
  logic [PIX_W-1:0]          in_col;

  assign in_shape  = s_axis_tdata_i[7:0];
  assign in_cx     = s_axis_tdata_i[26:8];
  assign in_cy     = s_axis_tdata_i[45:27];
  assign in_radius = s_axis_tdata_i[64:46];
  assign in_paint  = s_axis_tdata_i[72:65];
  assign in_row    = s_axis_tdata_i[81:73];
  assign in_col    = s_axis_tdata_i[90:82];

  // Configuration registers.
  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;
  logic [CHAR_W-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_CANVAS_WIDTH;
      height_q <= RST_CANVAS_HEIGHT;
      bg_q     <= RST_BACKGROUND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  width_q  <= cfg_data_i;
        CFG_CANVAS_HEIGHT: height_q <= cfg_data_i;
        CFG_BACKGROUND:    bg_q     <= cfg_data_i[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // In-use size, saturated to the canvas memory.
  logic [WCMP_W-1:0]    w_ext;
  logic [HCMP_W-1:0]    h_ext;
  logic [COL_CNT_W-1:0] used_w;
  logic [ROW_CNT_W-1:0] used_h;

  assign w_ext  = WCMP_W'(width_q);
  assign h_ext  = HCMP_W'(height_q);
  assign used_w = (w_ext > WCMP_W'(MAX_WIDTH)) ? COL_CNT_W'(MAX_WIDTH) : COL_CNT_W'(w_ext);
  assign used_h = (h_ext > HCMP_W'(MAX_HEIGHT)) ? ROW_CNT_W'(MAX_HEIGHT) : ROW_CNT_W'(h_ext);

  // Command decode.
  logic in_accept;
  logic shape_ok;
  logic radius_ok;
  logic read_hit;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign shape_ok  = (in_shape == SHAPE_LOWER) || (in_shape == SHAPE_UPPER);
  assign radius_ok = !in_radius[COORD_W-1] && (in_radius != '0);
  assign read_hit  = (PCMP_W'(in_row) < PCMP_W'(used_h)) && (PCMP_W'(in_col) < PCMP_W'(used_w));

  // Canvas memory and raster engine.
  state_e            state_q;
  logic              corrupt_q;
  logic [CHAR_W-1:0] value_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_pix_q;
  logic              out_corr_q;

  sweep_req_t        sweep_req;
  logic              sweep_start;
  logic              sweep_done;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  assign sweep_req.is_clear  = (s_axis_tuser_i == FUNC_CLEAR);
  assign sweep_req.fill_char = (s_axis_tuser_i == FUNC_CLEAR) ? bg_q : in_paint;
  assign sweep_req.cx        = in_cx;
  assign sweep_req.cy        = in_cy;
  assign sweep_req.radius    = in_radius;

  assign sweep_start = in_accept && ((s_axis_tuser_i == FUNC_CLEAR) ||
                       ((s_axis_tuser_i == FUNC_DRAW) && !corrupt_q && shape_ok && radius_ok));
  assign ram_re      = in_accept && (s_axis_tuser_i == FUNC_READ) && read_hit;
  assign ram_raddr   = ADDR_W'(in_row * MAX_WIDTH) + ADDR_W'(in_col);

  cfr_sweep #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sweep_start),
    .req_i    (sweep_req),
    .used_w_i (used_w),
    .used_h_i (used_h),
    .done_o   (sweep_done),
    .we_o     (ram_we),
    .waddr_o  (ram_waddr),
    .wdata_o  (ram_wdata)
  );

  cfr_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command controller, corrupted flag and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      corrupt_q   <= 1'b0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_corr_q  <= 1'b0;
    end else begin
      // A result taken while the next one is being loaded is replaced below.
      if (out_valid_q && m_axis_tready_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            value_q <= '0;
            unique case (s_axis_tuser_i)
              FUNC_CLEAR: begin
                corrupt_q <= 1'b0;
                state_q   <= ST_SWEEP;
              end
              FUNC_DRAW: begin
                if (sweep_start) begin
                  state_q <= ST_SWEEP;
                end else begin
                  corrupt_q <= 1'b1;
                  state_q   <= ST_RESULT;
                end
              end
              FUNC_READ: state_q <= read_hit ? ST_READ : ST_RESULT;
              default:   state_q <= ST_RESULT;
            endcase
          end
        end
        ST_SWEEP: begin
          if (sweep_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_READ: begin
          value_q <= ram_rdata;
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= value_q;
            out_corr_q  <= corrupt_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - CHAR_W - 1)'(0), out_corr_q, out_pix_q};

`ifndef NO_ASSERTIONS
  // The canvas is only written while a clear or draw is in progress.
  a_write_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SWEEP))
    else $error("canvas write outside a sweep");

  // The raster engine only finishes a sweep the controller is waiting for.
  a_done_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_done |-> (state_q == ST_SWEEP))
    else $error("sweep completion while controller not waiting");

  // The corrupted flag only rises on an accepted draw.
  a_corrupt_rise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(corrupt_q) |-> $past(in_accept && (s_axis_tuser_i == FUNC_DRAW)))
    else $error("corrupted flag set without a draw");
`endif

endmodule

`default_nettype wire
